>>> rtl/core/window_blind_servo_controller_macros.svh
// Assertion macros shared by the blind controller RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef WINDOW_BLIND_SERVO_CONTROLLER_MACROS_SVH
`define WINDOW_BLIND_SERVO_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WBSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define WBSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/wbsc_pkg.sv
package wbsc_pkg;

    localparam int SENSOR_BITS = 10;
    localparam int TIMER_BITS  = 16;
    localparam int CFG_BITS    = 16;
    localparam int PULSE_BITS  = 12;
    localparam int THRESH_BITS = 10;

    // Width used to compare a timer against a 16-bit configuration value.
    localparam int CMP_W = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    // Width of the light comparison sum, one bit above the wider operand.
    localparam int SUM_W = ((SENSOR_BITS > THRESH_BITS) ? SENSOR_BITS : THRESH_BITS) + 1;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    localparam logic [PULSE_BITS-1:0] PULSE_CLOSE_US = PULSE_BITS'(2300);
    localparam logic [PULSE_BITS-1:0] PULSE_OPEN_US  = PULSE_BITS'(800);

    typedef enum logic [2:0] {
        REG_AUTO_MODE       = 3'd0,
        REG_THRESHOLD       = 3'd1,
        REG_SAMPLE_PERIOD   = 3'd2,
        REG_TRAVEL_TIME     = 3'd3,
        REG_HOMING_PULSE    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [SENSOR_BITS-1:0] inside_level;
        logic [SENSOR_BITS-1:0] outside_level;
        logic                   request_valid;
        logic                   request_open;
    } in_t;

    typedef struct packed {
        logic                   servo_enabled;
        logic [PULSE_BITS-1:0]  pulse_width_us;
        logic                   mode_open;
        logic [SENSOR_BITS-1:0] held_outside;
    } out_t;

    typedef struct packed {
        logic                   auto_mode;
        logic [THRESH_BITS-1:0] brightness_threshold;
        logic [CFG_BITS-1:0]    sample_period_ms;
        logic [CFG_BITS-1:0]    travel_time_ms;
        logic [PULSE_BITS-1:0]  homing_pulse_us;
    } cfg_t;

    typedef struct packed {
        logic [TIMER_BITS-1:0]  since_start_ms;
        logic [TIMER_BITS-1:0]  since_switch_ms;
        logic [TIMER_BITS-1:0]  since_sample_ms;
        logic [SENSOR_BITS-1:0] held_outside_level;
        logic                   current_mode;
        logic                   previous_mode;
        logic                   servo_attached;
        logic [PULSE_BITS-1:0]  servo_pulse;
    } state_t;

    localparam cfg_t CFG_RESET = '{
        auto_mode:            1'b0,
        brightness_threshold: THRESH_BITS'(50),
        sample_period_ms:     CFG_BITS'(5000),
        travel_time_ms:       CFG_BITS'(10000),
        homing_pulse_us:      PULSE_BITS'(2300)
    };

    localparam state_t STATE_RESET = '{
        since_start_ms:     '0,
        since_switch_ms:    '0,
        since_sample_ms:    '0,
        held_outside_level: '0,
        current_mode:       1'b0,
        previous_mode:      1'b0,
        servo_attached:     1'b1,
        servo_pulse:        PULSE_BITS'(2300)
    };

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

endpackage

>>> rtl/core/wbsc_tick.sv
module wbsc_tick
    import wbsc_pkg::*;
(
    input  cfg_t   cfg,
    input  state_t state,
    input  in_t    item,
    output state_t state_next,
    output out_t   result_next
);

    always_comb
    begin
        logic                  switch_ok;
        logic                  want_open;
        logic                  refresh;
        logic [SUM_W-1:0]      held_plus_thr;
        logic [SUM_W-1:0]      inside_ext;
        logic [CMP_W-1:0]      travel_w;

        travel_w   = CMP_W'(cfg.travel_time_ms);
        state_next = state;

        state_next.since_start_ms  = sat_inc(state.since_start_ms);
        state_next.since_switch_ms = sat_inc(state.since_switch_ms);
        state_next.since_sample_ms = sat_inc(state.since_sample_ms);

        // Manual request is applied first.
        switch_ok = CMP_W'(state_next.since_switch_ms) > travel_w;
        if (item.request_valid && (item.request_open != state_next.current_mode) && switch_ok)
        begin
            state_next.servo_attached  = 1'b1;
            state_next.since_switch_ms = '0;
            state_next.previous_mode   = state_next.current_mode;
            state_next.current_mode    = item.request_open;
        end

        // The outside sample is refreshed at most once per tick, in auto mode or after homing.
        refresh = (cfg.auto_mode || (CMP_W'(state_next.since_start_ms) >= travel_w))
                  && (CMP_W'(state_next.since_sample_ms) > CMP_W'(cfg.sample_period_ms));
        if (refresh)
        begin
            state_next.held_outside_level = item.outside_level;
            state_next.since_sample_ms    = '0;
        end

        // Close when held + threshold < inside, which is held < inside - threshold.
        held_plus_thr = SUM_W'(state_next.held_outside_level)
                        + SUM_W'(cfg.brightness_threshold);
        inside_ext    = SUM_W'(item.inside_level);
        want_open     = !(held_plus_thr < inside_ext);
        switch_ok     = CMP_W'(state_next.since_switch_ms) > travel_w;
        if (cfg.auto_mode && (want_open != state_next.current_mode) && switch_ok)
        begin
            state_next.servo_attached  = 1'b1;
            state_next.since_switch_ms = '0;
            state_next.previous_mode   = state_next.current_mode;
            state_next.current_mode    = want_open;
        end

        if (CMP_W'(state_next.since_start_ms) < travel_w)
        begin
            state_next.servo_pulse = cfg.homing_pulse_us;
        end
        else if (CMP_W'(state_next.since_switch_ms) < (travel_w >> 1))
        begin
            if (state_next.previous_mode != state_next.current_mode)
            begin
                state_next.servo_pulse = state_next.current_mode ? PULSE_OPEN_US
                                                                 : PULSE_CLOSE_US;
            end
        end
        else
        begin
            state_next.previous_mode  = state_next.current_mode;
            state_next.servo_attached = 1'b0;
        end

        result_next.servo_enabled  = state_next.servo_attached;
        result_next.pulse_width_us = state_next.servo_attached ? state_next.servo_pulse : '0;
        result_next.mode_open      = state_next.current_mode;
        result_next.held_outside   = state_next.held_outside_level;
    end

endmodule

>>> rtl/core/window_blind_servo_controller.sv
// A transaction accepted into the input register moves on to the result register when that
// register is free, and its result is offered from there until it is taken.
// Throughput: one transaction per cycle while result_stall is low; the input register and the
// result register form a two-entry pipeline, so a new tick is taken while a finished result waits.
// Reset (rst_n, asynchronous, active low) clears both pipeline stages, restores the
// configuration defaults and puts the controller in its homing state with the servo attached.
`include "window_blind_servo_controller_macros.svh"

module window_blind_servo_controller
    import wbsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,

    input  logic                item_valid,
    output logic                item_stall,
    input  in_t                 item,

    output logic                result_valid,
    input  logic                result_stall,
    output out_t                result
);

    // Configuration registers; the user must write them only while the controller is idle (not enforced).
    cfg_t   cfg_reg;

    // Controller state: timers, held outside level, modes and servo drive.
    state_t state_reg;
    state_t state_next;

    // Input stage holds one accepted tick until the result register can take it.
    logic   s1_valid_reg;
    in_t    s1_item_reg;

    // Result stage.
    logic   result_valid_reg;
    out_t   result_reg;
    out_t   result_next;

    logic   out_free;
    logic   item_fire;
    logic   s1_fire;

    // The result register is free when empty or when its transaction leaves this cycle.
    assign out_free   = !result_valid_reg || !result_stall;
    // The input register can refill whenever its contents move on in the same cycle.
    assign item_stall = s1_valid_reg && !out_free;
    assign item_fire  = item_valid && !item_stall;
    // The held tick is processed, and the state advances, when it moves to the result stage.
    assign s1_fire    = s1_valid_reg && out_free;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // All per-tick arithmetic sits between the input register and the result register.
    wbsc_tick u_tick (
        .cfg         (cfg_reg),
        .state       (state_reg),
        .item        (s1_item_reg),
        .state_next  (state_next),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_AUTO_MODE:     cfg_reg.auto_mode            <= cfg_data[0];
                REG_THRESHOLD:     cfg_reg.brightness_threshold <= cfg_data[THRESH_BITS-1:0];
                REG_SAMPLE_PERIOD: cfg_reg.sample_period_ms     <= cfg_data;
                REG_TRAVEL_TIME:   cfg_reg.travel_time_ms       <= cfg_data;
                REG_HOMING_PULSE:  cfg_reg.homing_pulse_us      <= cfg_data[PULSE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= STATE_RESET;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_free)
            begin
                result_valid_reg <= s1_valid_reg;
            end

            if (s1_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_item_reg <= item;
        end
        if (s1_fire)
        begin
            result_reg <= result_next;
        end
    end

    // An empty input stage never holds back the upstream side.
    `WBSC_ASSERT_SAME(a_no_stall_when_empty, !s1_valid_reg, !item_stall)
    // The controller state only moves when a tick is processed.
    `WBSC_ASSERT_NEXT(a_state_holds_when_idle, !s1_fire, $stable(state_reg))
    // A released servo is never reported with a nonzero pulse.
    `WBSC_ASSERT_SAME(a_released_pulse_zero, result_valid_reg && !result_reg.servo_enabled,
                      result_reg.pulse_width_us == '0)

endmodule
